// File: rtl/rttsa_pkg.sv
// Shared types, widths and constants for the RTT statistics accumulator.
package rttsa_pkg;

	localparam int RTT_W    = 20;
	localparam int CNT_W    = 12;
	localparam int SUM_W    = 32;
	localparam int SQ_W     = 52;
	localparam int VAR_W    = 38;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int DIV_W    = PROD_W;

	localparam int MAX_SAMPLES_DEF = 4095;
	localparam int SAMPLE_BITS_DEF = 20;

	// divider retires this many quotient bits per cycle
	localparam int DIV_STEPS = 2;
	localparam int DIV_CYC_W = 6;

	localparam logic [DIV_CYC_W-1:0] MEAN_CYC = DIV_CYC_W'(SUM_W / DIV_STEPS);
	localparam logic [DIV_CYC_W-1:0] CORR_CYC = DIV_CYC_W'(PROD_W / DIV_STEPS);
	localparam logic [DIV_CYC_W-1:0] VAR_CYC  = DIV_CYC_W'(SQ_W / DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SQSUM,
		ST_MEAN,
		ST_CORR,
		ST_VAR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 go;
		logic [DIV_W-1:0]     dividend;   // left aligned
		logic [DIV_CYC_W-1:0] cycles;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;      // right aligned
	} div_rsp_t;

endpackage

// File: rtl/rttsa_if.sv
// Valid/ready channel interfaces for samples and statistics results.
interface rttsa_in_if;
	logic                        valid;
	logic                        ready;
	logic [rttsa_pkg::RTT_W-1:0] rtt_us;
	logic                        start_run;

	modport source(output valid, rtt_us, start_run, input ready);
	modport sink(input valid, rtt_us, start_run, output ready);
endinterface

interface rttsa_res_if;
	logic                        valid;
	logic                        ready;
	logic [rttsa_pkg::CNT_W-1:0] sample_total;
	logic [rttsa_pkg::RTT_W-1:0] min_rtt;
	logic [rttsa_pkg::RTT_W-1:0] max_rtt;
	logic [rttsa_pkg::RTT_W-1:0] mean_rtt;
	logic [rttsa_pkg::VAR_W-1:0] variance_rtt;
	logic                        dropped;

	modport source(output valid, sample_total, min_rtt, max_rtt, mean_rtt, variance_rtt,
		dropped, input ready);
	modport sink(input valid, sample_total, min_rtt, max_rtt, mean_rtt, variance_rtt,
		dropped, output ready);
endinterface

// File: rtl/rttsa_div.sv
// Shared restoring divider, 64-bit dividend by the 12-bit sample count.
module rttsa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rttsa_pkg::div_req_t         req,
	input  logic [rttsa_pkg::CNT_W-1:0] divisor,
	output rttsa_pkg::div_rsp_t         rsp
);

	logic [rttsa_pkg::DIV_W-1:0]     dq_q;    // dividend bits out the top, quotient in
	logic [rttsa_pkg::CNT_W-1:0]     rem_q;
	logic [rttsa_pkg::DIV_CYC_W-1:0] cnt_q;
	logic                            done_q;

	logic [rttsa_pkg::DIV_W-1:0] dq_nxt;
	logic [rttsa_pkg::CNT_W-1:0] rem_nxt;

	always_comb begin
		logic [rttsa_pkg::CNT_W:0] t;
		logic                      ge;
		dq_nxt  = dq_q;
		rem_nxt = rem_q;
		for (int i = 0; i < rttsa_pkg::DIV_STEPS; i++) begin
			t       = {rem_nxt, dq_nxt[rttsa_pkg::DIV_W-1]};
			ge      = (t >= {1'b0, divisor});
			dq_nxt  = {dq_nxt[rttsa_pkg::DIV_W-2:0], ge};
			rem_nxt = ge ? rttsa_pkg::CNT_W'(t - {1'b0, divisor})
				: rttsa_pkg::CNT_W'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == rttsa_pkg::DIV_CYC_W'(1));
			if (req.go)
				cnt_q <= req.cycles;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - rttsa_pkg::DIV_CYC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dq_q  <= dq_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

// File: rtl/rtt_statistics_accumulator.sv
// Top level: running count, min, max, mean and population variance of RTT samples.
// States per sample: UPDATE, SQSUM, MEAN, CORR, VAR, then EMIT loads the result.
// A new sample is taken only in IDLE, once the last is through; the shared divider
//   runs three divisions by the count at two quotient bits a cycle.
// A finished result sits in an output register; the next sample is taken meanwhile.
// Reset (arst_n low, asynchronous) empties the run: count 0, min all ones, max 0.
module rtt_statistics_accumulator #(
	parameter int MAX_SAMPLES = rttsa_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = rttsa_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rttsa_in_if.sink     samples,
	rttsa_res_if.source  results
);

	localparam int RTT_W  = rttsa_pkg::RTT_W;
	localparam int CNT_W  = rttsa_pkg::CNT_W;
	localparam int SUM_W  = rttsa_pkg::SUM_W;
	localparam int SQ_W   = rttsa_pkg::SQ_W;
	localparam int VAR_W  = rttsa_pkg::VAR_W;
	localparam int MUL_W  = rttsa_pkg::MUL_W;
	localparam int PROD_W = rttsa_pkg::PROD_W;
	localparam int DIV_W  = rttsa_pkg::DIV_W;

	// only the low SAMPLE_BITS of a sample count
	localparam logic [RTT_W-1:0] SMASK = RTT_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

	rttsa_pkg::state_t state_q, state_nxt;

	// latched transaction
	logic [RTT_W-1:0] samp_q;
	logic             start_q;
	logic             drop_q;

	// run accumulators
	logic [CNT_W-1:0] count_q;
	logic [RTT_W-1:0] min_q;
	logic [RTT_W-1:0] max_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sumsq_q;

	// shared multiplier: sample squared, then sum squared
	logic [MUL_W-1:0]  mul_a;
	logic [PROD_W-1:0] prod_q;

	logic [RTT_W-1:0] mean_q;
	logic [VAR_W-1:0] var_q;

	// output register
	logic             res_valid_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [RTT_W-1:0] res_min_q;
	logic [RTT_W-1:0] res_max_q;
	logic [RTT_W-1:0] res_mean_q;
	logic [VAR_W-1:0] res_var_q;
	logic             res_drop_q;

	rttsa_pkg::div_req_t div_req;
	rttsa_pkg::div_rsp_t div_rsp;

	logic             out_free;
	logic             res_load;
	logic [CNT_W-1:0] cnt_eff;
	logic [RTT_W-1:0] min_eff;
	logic [RTT_W-1:0] max_eff;
	logic [SUM_W-1:0] sum_eff;
	logic             drop_c;
	logic [SQ_W-1:0]  diff;

	// start_run clears the run before this sample is folded in
	assign cnt_eff = start_q ? '0 : count_q;
	assign min_eff = start_q ? '1 : min_q;
	assign max_eff = start_q ? '0 : max_q;
	assign sum_eff = start_q ? '0 : sum_q;
	assign drop_c  = (cnt_eff >= CNT_MAX);

	// sumsq - floor(sum^2/n), floored at zero; corr comes straight off the divider
	assign diff = ({{(DIV_W-SQ_W){1'b0}}, sumsq_q} >= div_rsp.quotient)
		? SQ_W'({{(DIV_W-SQ_W){1'b0}}, sumsq_q} - div_rsp.quotient) : '0;

	assign out_free = !res_valid_q || results.ready;

	rttsa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (count_q),
		.rsp     (div_rsp)
	);

	// sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rttsa_pkg::ST_IDLE:   if (samples.valid) state_nxt = rttsa_pkg::ST_UPDATE;
			rttsa_pkg::ST_UPDATE: state_nxt = rttsa_pkg::ST_SQSUM;
			rttsa_pkg::ST_SQSUM:  state_nxt = rttsa_pkg::ST_MEAN;
			rttsa_pkg::ST_MEAN:   if (div_rsp.done) state_nxt = rttsa_pkg::ST_CORR;
			rttsa_pkg::ST_CORR:   if (div_rsp.done) state_nxt = rttsa_pkg::ST_VAR;
			rttsa_pkg::ST_VAR:    if (div_rsp.done) state_nxt = rttsa_pkg::ST_EMIT;
			rttsa_pkg::ST_EMIT:   if (out_free) state_nxt = rttsa_pkg::ST_IDLE;
			default:              state_nxt = rttsa_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		samples.ready   = 1'b0;
		res_load        = 1'b0;
		mul_a           = sum_q;
		div_req.go      = 1'b0;
		div_req.dividend = {sum_q, {(DIV_W-SUM_W){1'b0}}};
		div_req.cycles  = rttsa_pkg::MEAN_CYC;
		unique case (state_q)
			rttsa_pkg::ST_IDLE:   samples.ready = 1'b1;
			rttsa_pkg::ST_UPDATE: mul_a = MUL_W'(samp_q);
			rttsa_pkg::ST_SQSUM:  div_req.go = 1'b1;   // mean = sum / n
			rttsa_pkg::ST_MEAN: begin
				// corr = sum^2 / n
				div_req.go       = div_rsp.done;
				div_req.dividend = prod_q;
				div_req.cycles   = rttsa_pkg::CORR_CYC;
			end
			rttsa_pkg::ST_CORR: begin
				// variance = diff / n
				div_req.go       = div_rsp.done;
				div_req.dividend = {diff, {(DIV_W-SQ_W){1'b0}}};
				div_req.cycles   = rttsa_pkg::VAR_CYC;
			end
			rttsa_pkg::ST_VAR:    ;
			rttsa_pkg::ST_EMIT:   res_load = out_free;
			default:              ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rttsa_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (state_q == rttsa_pkg::ST_UPDATE) begin
			count_q <= drop_c ? cnt_eff : cnt_eff + CNT_W'(1);
			min_q   <= (!drop_c && samp_q < min_eff) ? samp_q : min_eff;
			max_q   <= (!drop_c && samp_q > max_eff) ? samp_q : max_eff;
			sum_q   <= drop_c ? sum_eff : sum_eff + SUM_W'(samp_q);
			if (start_q)
				sumsq_q <= '0;
		end else if (state_q == rttsa_pkg::ST_SQSUM && !drop_q) begin
			sumsq_q <= sumsq_q + SQ_W'(prod_q);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			samp_q  <= samples.rtt_us & SMASK;
			start_q <= samples.start_run;
		end
		if (state_q == rttsa_pkg::ST_UPDATE)
			drop_q <= drop_c;
		// operands zero-extended so the full 32x32 product is kept
		if (state_q == rttsa_pkg::ST_UPDATE || state_q == rttsa_pkg::ST_SQSUM)
			prod_q <= {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_a};
		if (state_q == rttsa_pkg::ST_MEAN && div_rsp.done)
			mean_q <= div_rsp.quotient[RTT_W-1:0];
		if (state_q == rttsa_pkg::ST_VAR && div_rsp.done)
			var_q <= div_rsp.quotient[VAR_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (results.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_cnt_q  <= count_q;
			res_min_q  <= min_q;
			res_max_q  <= max_q;
			res_mean_q <= mean_q;
			res_var_q  <= var_q;
			res_drop_q <= drop_q;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.sample_total = res_cnt_q;
	assign results.min_rtt      = res_min_q;
	assign results.max_rtt      = res_max_q;
	assign results.mean_rtt     = res_mean_q;
	assign results.variance_rtt = res_var_q;
	assign results.dropped      = res_drop_q;

	// run never grows past capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("sample count above capacity");

	// a non-empty run keeps min <= max
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> min_q <= max_q)
		else $error("min above max in a non-empty run");

	// divider never runs with a zero count
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.go |-> count_q != '0)
		else $error("division by zero count");

	// divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == rttsa_pkg::ST_MEAN || state_q == rttsa_pkg::ST_CORR
			|| state_q == rttsa_pkg::ST_VAR))
		else $error("divider done outside a wait state");

	// an accepted transaction starts the update next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> state_q == rttsa_pkg::ST_UPDATE)
		else $error("accepted sample not processed");

endmodule
